// ----- rtl/core/json_byte_tokenizer_macros.svh -----
// ----------------------------------------------------------------------------
// JSON byte tokenizer assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef JSON_BYTE_TOKENIZER_MACROS_SVH
`define JSON_BYTE_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
`define JBT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jbt assertion failed");
`define JBT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jbt assertion failed");
`else
`define JBT_ASSERT_IMP(label, ante, cons)
`define JBT_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/jbt_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON byte tokenizer package
// Token codes, character constants and literal store sizing.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int LIT_BYTES = 5;
  localparam int LIT_CNT_W = $clog2(LIT_BYTES + 1);

  typedef enum logic [3:0] {
    TK_CONTENT   = 4'd0,
    TK_LBRACE    = 4'd1,
    TK_RBRACE    = 4'd2,
    TK_LBRACKET  = 4'd3,
    TK_RBRACKET  = 4'd4,
    TK_COLON     = 4'd5,
    TK_COMMA     = 4'd6,
    TK_STR_END   = 4'd7,
    TK_INT_END   = 4'd8,
    TK_FLOAT_END = 4'd9,
    TK_TRUE      = 4'd10,
    TK_FALSE     = 4'd11,
    TK_NULL      = 4'd12,
    TK_EOF       = 4'd13,
    TK_UNKNOWN   = 4'd14
  } tok_kind_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;

  localparam logic [31:0] WORD_TRUE  = "true";
  localparam logic [39:0] WORD_FALSE = "false";
  localparam logic [31:0] WORD_NULL  = "null";

endpackage

// ----- rtl/core/jbt_in_if.sv -----
// ----------------------------------------------------------------------------
// JSON byte tokenizer input channel
// Valid/ready channel carrying one character byte or an end-of-input mark.
// ----------------------------------------------------------------------------
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- rtl/core/jbt_out_if.sv -----
// ----------------------------------------------------------------------------
// JSON byte tokenizer output channel
// Valid/ready channel carrying one token with its text byte and last flag.
// ----------------------------------------------------------------------------
interface jbt_out_if;
  logic              valid;
  logic              ready;
  jbt_pkg::tok_kind_t token_kind;
  logic [7:0]        content;
  logic              last;

  modport source (output valid, output token_kind, output content, output last,
                  input ready);
  modport sink (input valid, input token_kind, input content, input last,
                output ready);
endinterface

// ----- rtl/core/json_byte_tokenizer.sv -----
// ----------------------------------------------------------------------------
// JSON byte tokenizer
// Streaming JSON lexer: one byte per transfer in, zero to two tokens out.
// ----------------------------------------------------------------------------
//  channel    | dir | payload                         | handshake
//  byte_in    | in  | in_byte, end_of_input           | valid/ready
//  token_out  | out | token_kind, content, last       | valid/ready
//
//  One byte per cycle sustained while token_out is ready; a byte that yields
//  two tokens holds the input side while its first token drains, as the result
//  register drains one token per cycle. Input register feeds result register.
//  Reset (rst, synchronous) returns the lexer to idle with empty buffers.
//  Stalls on token_out back up through the result register into byte_in.
// ----------------------------------------------------------------------------
`include "json_byte_tokenizer_macros.svh"

module json_byte_tokenizer (
  input  logic        clk,
  input  logic        rst,
  jbt_in_if.sink      byte_in,
  jbt_out_if.source   token_out
);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_STRING, M_SIGN, M_INT, M_FRAC, M_EXP, M_EXPD, M_LIT
  } mode_t;

  typedef logic [jbt_pkg::LIT_BYTES-1:0][7:0] lit_arr_t;

  typedef struct packed {
    logic               emit;
    jbt_pkg::tok_kind_t kind;
    logic [7:0]         byt;
    mode_t              mode;
    logic               lit_start;
    logic               hold_sign;
    logic               clr_float;
  } idle_res_t;

  typedef struct packed {
    jbt_pkg::tok_kind_t kind;
    logic [7:0]         content;
    logic               last;
  } token_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == jbt_pkg::CH_SPACE || c == jbt_pkg::CH_TAB || c == jbt_pkg::CH_NL ||
           c == jbt_pkg::CH_VT || c == jbt_pkg::CH_FF || c == jbt_pkg::CH_CR;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= jbt_pkg::CH_ZERO && c <= jbt_pkg::CH_NINE;
  endfunction

  // TK_CONTENT means not structural
  function automatic jbt_pkg::tok_kind_t struct_kind(input logic [7:0] c);
    jbt_pkg::tok_kind_t k;
    k = jbt_pkg::TK_CONTENT;
    unique case (c)
      jbt_pkg::CH_LBRACE:   k = jbt_pkg::TK_LBRACE;
      jbt_pkg::CH_RBRACE:   k = jbt_pkg::TK_RBRACE;
      jbt_pkg::CH_LBRACKET: k = jbt_pkg::TK_LBRACKET;
      jbt_pkg::CH_RBRACKET: k = jbt_pkg::TK_RBRACKET;
      jbt_pkg::CH_COLON:    k = jbt_pkg::TK_COLON;
      jbt_pkg::CH_COMMA:    k = jbt_pkg::TK_COMMA;
      default:              k = jbt_pkg::TK_CONTENT;
    endcase
    return k;
  endfunction

  function automatic jbt_pkg::tok_kind_t lit_kind(input lit_arr_t lb,
                                                  input logic [jbt_pkg::LIT_CNT_W-1:0] cnt,
                                                  input logic over);
    jbt_pkg::tok_kind_t k;
    k = jbt_pkg::TK_UNKNOWN;
    if (!over) begin
      priority if (cnt == jbt_pkg::LIT_CNT_W'(4) &&
                   {lb[0], lb[1], lb[2], lb[3]} == jbt_pkg::WORD_TRUE) begin
        k = jbt_pkg::TK_TRUE;
      end else if (cnt == jbt_pkg::LIT_CNT_W'(5) &&
                   {lb[0], lb[1], lb[2], lb[3], lb[4]} == jbt_pkg::WORD_FALSE) begin
        k = jbt_pkg::TK_FALSE;
      end else if (cnt == jbt_pkg::LIT_CNT_W'(4) &&
                   {lb[0], lb[1], lb[2], lb[3]} == jbt_pkg::WORD_NULL) begin
        k = jbt_pkg::TK_NULL;
      end else begin
        k = jbt_pkg::TK_UNKNOWN;
      end
    end
    return k;
  endfunction

  function automatic idle_res_t idle_step(input logic [7:0] c);
    idle_res_t          r;
    jbt_pkg::tok_kind_t sk;
    sk          = struct_kind(c);
    r.emit      = 1'b0;
    r.kind      = jbt_pkg::TK_CONTENT;
    r.byt       = 8'h00;
    r.mode      = M_IDLE;
    r.lit_start = 1'b0;
    r.hold_sign = 1'b0;
    r.clr_float = 1'b0;
    priority if (sk != jbt_pkg::TK_CONTENT) begin
      r.emit = 1'b1;
      r.kind = sk;
    end else if (is_ws(c)) begin
      r.mode = M_IDLE;
    end else if (c == jbt_pkg::CH_SLASH) begin
      r.mode = M_COMMENT;
    end else if (c == jbt_pkg::CH_QUOTE) begin
      r.mode = M_STRING;
    end else if (is_dig(c)) begin
      r.emit      = 1'b1;
      r.byt       = c;
      r.mode      = M_INT;
      r.clr_float = 1'b1;
    end else if (c == jbt_pkg::CH_PLUS || c == jbt_pkg::CH_MINUS) begin
      r.mode      = M_SIGN;
      r.hold_sign = 1'b1;
    end else begin
      r.mode      = M_LIT;
      r.lit_start = 1'b1;
    end
    return r;
  endfunction

  // input register
  logic       d_valid;
  logic [7:0] d_byte;
  logic       d_eoi;

  // lexer state
  mode_t                          mode, mode_next;
  lit_arr_t                       lit_bytes, lit_bytes_next;
  logic [jbt_pkg::LIT_CNT_W-1:0]  lit_cnt, lit_cnt_next;
  logic                           lit_over, lit_over_next;
  logic [7:0]                     held_sign, held_sign_next;
  logic                           is_float, is_float_next;

  // result register
  token_t     o0, o1;
  logic [1:0] ocnt;

  jbt_pkg::tok_kind_t emit_kind [2];
  logic [7:0]         emit_byte [2];
  logic [1:0]         emit_n;
  logic               do_idle;
  idle_res_t          idle_r;
  jbt_pkg::tok_kind_t cur_lit_kind;
  logic               out_fire;
  logic               adv;

  assign out_fire     = token_out.valid && token_out.ready;
  assign adv          = d_valid && (ocnt == 2'd0 || (ocnt == 2'd1 && out_fire));
  assign byte_in.ready = !d_valid || adv;
  assign idle_r       = idle_step(d_byte);
  assign cur_lit_kind = lit_kind(lit_bytes, lit_cnt, lit_over);

  assign token_out.valid      = ocnt != 2'd0;
  assign token_out.token_kind = o0.kind;
  assign token_out.content    = o0.content;
  assign token_out.last       = o0.last;

  always_comb begin
    mode_next      = mode;
    lit_bytes_next = lit_bytes;
    lit_cnt_next   = lit_cnt;
    lit_over_next  = lit_over;
    held_sign_next = held_sign;
    is_float_next  = is_float;
    emit_kind[0]   = jbt_pkg::TK_CONTENT;
    emit_kind[1]   = jbt_pkg::TK_CONTENT;
    emit_byte[0]   = 8'h00;
    emit_byte[1]   = 8'h00;
    emit_n         = 2'd0;
    do_idle        = 1'b0;

    if (d_eoi) begin
      unique case (mode)
        M_STRING: begin
          emit_kind[emit_n[0]] = jbt_pkg::TK_STR_END;
          emit_n = emit_n + 2'd1;
        end
        M_SIGN: begin
          emit_kind[emit_n[0]] = jbt_pkg::TK_UNKNOWN;
          emit_n = emit_n + 2'd1;
        end
        M_INT, M_FRAC, M_EXP, M_EXPD: begin
          emit_kind[emit_n[0]] = is_float ? jbt_pkg::TK_FLOAT_END : jbt_pkg::TK_INT_END;
          emit_n = emit_n + 2'd1;
        end
        M_LIT: begin
          emit_kind[emit_n[0]] = cur_lit_kind;
          emit_n = emit_n + 2'd1;
        end
        default: begin
        end
      endcase
      emit_kind[emit_n[0]] = jbt_pkg::TK_EOF;
      emit_n         = emit_n + 2'd1;
      mode_next      = M_IDLE;
      lit_bytes_next = '0;
      lit_cnt_next   = '0;
      lit_over_next  = 1'b0;
      held_sign_next = 8'h00;
      is_float_next  = 1'b0;
    end else begin
      unique case (mode)
        M_COMMENT: begin
          if (d_byte == jbt_pkg::CH_NL) mode_next = M_IDLE;
        end
        M_STRING: begin
          if (d_byte == jbt_pkg::CH_QUOTE) begin
            emit_kind[emit_n[0]] = jbt_pkg::TK_STR_END;
            mode_next = M_IDLE;
          end else begin
            emit_byte[emit_n[0]] = d_byte;
          end
          emit_n = emit_n + 2'd1;
        end
        M_SIGN: begin
          if (is_dig(d_byte)) begin
            is_float_next = 1'b0;
            emit_byte[0]  = held_sign;
            emit_byte[1]  = d_byte;
            emit_n        = 2'd2;
            mode_next     = M_INT;
          end else if (is_ws(d_byte) || struct_kind(d_byte) != jbt_pkg::TK_CONTENT) begin
            // a lone sign is a one-byte literal, never a known word
            emit_kind[emit_n[0]] = jbt_pkg::TK_UNKNOWN;
            emit_n  = emit_n + 2'd1;
            do_idle = 1'b1;
          end else begin
            lit_bytes_next    = '0;
            lit_bytes_next[0] = held_sign;
            lit_bytes_next[1] = d_byte;
            lit_cnt_next      = jbt_pkg::LIT_CNT_W'(2);
            lit_over_next     = 1'b0;
            mode_next         = M_LIT;
          end
          held_sign_next = 8'h00;
        end
        M_INT: begin
          if (is_dig(d_byte)) begin
            emit_byte[emit_n[0]] = d_byte;
            emit_n = emit_n + 2'd1;
          end else if (d_byte == jbt_pkg::CH_DOT) begin
            is_float_next = 1'b1;
            emit_byte[emit_n[0]] = d_byte;
            emit_n    = emit_n + 2'd1;
            mode_next = M_FRAC;
          end else if (d_byte == jbt_pkg::CH_E_LO || d_byte == jbt_pkg::CH_E_UP) begin
            is_float_next = 1'b1;
            emit_byte[emit_n[0]] = d_byte;
            emit_n    = emit_n + 2'd1;
            mode_next = M_EXP;
          end else begin
            emit_kind[emit_n[0]] = is_float ? jbt_pkg::TK_FLOAT_END : jbt_pkg::TK_INT_END;
            emit_n        = emit_n + 2'd1;
            is_float_next = 1'b0;
            do_idle       = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_dig(d_byte)) begin
            emit_byte[emit_n[0]] = d_byte;
            emit_n = emit_n + 2'd1;
          end else if (d_byte == jbt_pkg::CH_E_LO || d_byte == jbt_pkg::CH_E_UP) begin
            emit_byte[emit_n[0]] = d_byte;
            emit_n    = emit_n + 2'd1;
            mode_next = M_EXP;
          end else begin
            emit_kind[emit_n[0]] = is_float ? jbt_pkg::TK_FLOAT_END : jbt_pkg::TK_INT_END;
            emit_n        = emit_n + 2'd1;
            is_float_next = 1'b0;
            do_idle       = 1'b1;
          end
        end
        M_EXP: begin
          if (is_dig(d_byte) || d_byte == jbt_pkg::CH_PLUS || d_byte == jbt_pkg::CH_MINUS) begin
            emit_byte[emit_n[0]] = d_byte;
            emit_n    = emit_n + 2'd1;
            mode_next = M_EXPD;
          end else begin
            emit_kind[emit_n[0]] = is_float ? jbt_pkg::TK_FLOAT_END : jbt_pkg::TK_INT_END;
            emit_n        = emit_n + 2'd1;
            is_float_next = 1'b0;
            do_idle       = 1'b1;
          end
        end
        M_EXPD: begin
          if (is_dig(d_byte)) begin
            emit_byte[emit_n[0]] = d_byte;
            emit_n = emit_n + 2'd1;
          end else begin
            emit_kind[emit_n[0]] = is_float ? jbt_pkg::TK_FLOAT_END : jbt_pkg::TK_INT_END;
            emit_n        = emit_n + 2'd1;
            is_float_next = 1'b0;
            do_idle       = 1'b1;
          end
        end
        M_LIT: begin
          if (is_ws(d_byte) || struct_kind(d_byte) != jbt_pkg::TK_CONTENT) begin
            emit_kind[emit_n[0]] = cur_lit_kind;
            emit_n  = emit_n + 2'd1;
            do_idle = 1'b1;
          end else if (lit_cnt < jbt_pkg::LIT_CNT_W'(jbt_pkg::LIT_BYTES)) begin
            for (int i = 0; i < jbt_pkg::LIT_BYTES; i++) begin
              if (jbt_pkg::LIT_CNT_W'(i) == lit_cnt) lit_bytes_next[i] = d_byte;
            end
            lit_cnt_next = lit_cnt + jbt_pkg::LIT_CNT_W'(1);
          end else begin
            lit_over_next = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        if (idle_r.emit) begin
          emit_kind[emit_n[0]] = idle_r.kind;
          emit_byte[emit_n[0]] = idle_r.byt;
          emit_n = emit_n + 2'd1;
        end
        mode_next = idle_r.mode;
        if (idle_r.lit_start) begin
          lit_bytes_next    = '0;
          lit_bytes_next[0] = d_byte;
          lit_cnt_next      = jbt_pkg::LIT_CNT_W'(1);
          lit_over_next     = 1'b0;
        end
        if (idle_r.hold_sign) held_sign_next = d_byte;
        if (idle_r.clr_float) is_float_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      ocnt      <= 2'd0;
      mode      <= M_IDLE;
      lit_bytes <= '0;
      lit_cnt   <= '0;
      lit_over  <= 1'b0;
      held_sign <= 8'h00;
      is_float  <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        d_valid <= 1'b1;
        d_byte  <= byte_in.in_byte;
        d_eoi   <= byte_in.end_of_input;
      end else if (adv) begin
        d_valid <= 1'b0;
      end

      if (adv) begin
        ocnt       <= emit_n;
        mode       <= mode_next;
        lit_bytes  <= lit_bytes_next;
        lit_cnt    <= lit_cnt_next;
        lit_over   <= lit_over_next;
        held_sign  <= held_sign_next;
        is_float   <= is_float_next;
        o0.kind    <= emit_kind[0];
        o0.content <= emit_byte[0];
        o0.last    <= emit_n == 2'd1;
        o1.kind    <= emit_kind[1];
        o1.content <= emit_byte[1];
        o1.last    <= 1'b1;
      end else if (out_fire) begin
        ocnt <= (ocnt == 2'd2) ? 2'd1 : 2'd0;
        if (ocnt == 2'd2) o0 <= o1;
      end
    end
  end

  `JBT_ASSERT_IMP(a_pair_last, ocnt == 2'd2, !o0.last && o1.last)
  `JBT_ASSERT_NXT(a_pair_drain, out_fire && ocnt == 2'd2, ocnt == 2'd1)
  `JBT_ASSERT_NXT(a_eoi_clear, adv && d_eoi, mode == M_IDLE && lit_cnt == '0 && !lit_over)
  `JBT_ASSERT_IMP(a_lit_over_full, lit_over, lit_cnt == jbt_pkg::LIT_CNT_W'(jbt_pkg::LIT_BYTES))

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON byte tokenizer testbench
// Feeds byte streams through the input channel, predicts the token stream of
// every transfer in a local lexer model, and checks each output transfer in
// order. The stimulus runs through phases of source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 375;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [3:0] {
    LX_IDLE, LX_COMMENT, LX_STRING, LX_SIGN, LX_INT, LX_FRAC, LX_EXP, LX_EXPD, LX_LIT
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } lex_byte_t;

  typedef struct {
    jbt_pkg::tok_kind_t kind;
    logic [7:0]         text;
    logic               last;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jbt_in_if  byte_in_ch ();
  jbt_out_if token_out_ch ();

  json_byte_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in_ch),
    .token_out (token_out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lex_byte_t pending_bytes[$];
  token_t    expected_tokens[$];
  int        fail_count = 0;
  int        stim_count = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  logic      hold_go = 1'b0;
  logic      hold_sink = 1'b0;

  // lexer state
  lex_mode_t  lx_mode;
  logic [7:0] lit_buf [jbt_pkg::LIT_BYTES];
  int         lit_count;
  logic       lit_over;
  logic [7:0] held_sign;
  logic       lx_float;

  function automatic void lexer_clear();
    lx_mode = LX_IDLE;
    foreach (lit_buf[i]) lit_buf[i] = 8'h00;
    lit_count = 0;
    lit_over  = 1'b0;
    held_sign = 8'h00;
    lx_float  = 1'b0;
  endfunction

  function automatic void push_token(jbt_pkg::tok_kind_t kind, logic [7:0] ch);
    token_t t;
    t.kind = kind;
    t.text = (kind == jbt_pkg::TK_CONTENT) ? ch : 8'h00;
    t.last = 1'b0;
    expected_tokens = {expected_tokens, t};
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == jbt_pkg::CH_SPACE || c == jbt_pkg::CH_TAB || c == jbt_pkg::CH_NL ||
           c == jbt_pkg::CH_VT || c == jbt_pkg::CH_FF || c == jbt_pkg::CH_CR;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= jbt_pkg::CH_ZERO && c <= jbt_pkg::CH_NINE;
  endfunction

  function automatic jbt_pkg::tok_kind_t struct_kind(logic [7:0] c);
    case (c)
      jbt_pkg::CH_LBRACE:   return jbt_pkg::TK_LBRACE;
      jbt_pkg::CH_RBRACE:   return jbt_pkg::TK_RBRACE;
      jbt_pkg::CH_LBRACKET: return jbt_pkg::TK_LBRACKET;
      jbt_pkg::CH_RBRACKET: return jbt_pkg::TK_RBRACKET;
      jbt_pkg::CH_COLON:    return jbt_pkg::TK_COLON;
      jbt_pkg::CH_COMMA:    return jbt_pkg::TK_COMMA;
      default:              return jbt_pkg::TK_CONTENT;
    endcase
  endfunction

  function automatic jbt_pkg::tok_kind_t lit_kind();
    if (lit_over) return jbt_pkg::TK_UNKNOWN;
    if (lit_count == 4 &&
        {lit_buf[0], lit_buf[1], lit_buf[2], lit_buf[3]} == jbt_pkg::WORD_TRUE)
      return jbt_pkg::TK_TRUE;
    if (lit_count == 5 &&
        {lit_buf[0], lit_buf[1], lit_buf[2], lit_buf[3], lit_buf[4]} == jbt_pkg::WORD_FALSE)
      return jbt_pkg::TK_FALSE;
    if (lit_count == 4 &&
        {lit_buf[0], lit_buf[1], lit_buf[2], lit_buf[3]} == jbt_pkg::WORD_NULL)
      return jbt_pkg::TK_NULL;
    return jbt_pkg::TK_UNKNOWN;
  endfunction

  function automatic void lit_add(logic [7:0] c);
    if (lit_count < jbt_pkg::LIT_BYTES) begin
      lit_buf[lit_count] = c;
      lit_count++;
    end else begin
      lit_over = 1'b1;
    end
  endfunction

  function automatic void lit_begin(logic [7:0] c);
    foreach (lit_buf[i]) lit_buf[i] = 8'h00;
    lit_count = 0;
    lit_over  = 1'b0;
    lx_mode   = LX_LIT;
    lit_add(c);
  endfunction

  function automatic void idle_byte(logic [7:0] c);
    jbt_pkg::tok_kind_t sk;
    sk = struct_kind(c);
    if (sk != jbt_pkg::TK_CONTENT) begin
      push_token(sk, 8'h00);
    end else if (is_space(c)) begin
    end else if (c == jbt_pkg::CH_SLASH) begin
      lx_mode = LX_COMMENT;
    end else if (c == jbt_pkg::CH_QUOTE) begin
      lx_mode = LX_STRING;
    end else if (is_digit(c)) begin
      lx_float = 1'b0;
      push_token(jbt_pkg::TK_CONTENT, c);
      lx_mode = LX_INT;
    end else if (c == jbt_pkg::CH_PLUS || c == jbt_pkg::CH_MINUS) begin
      held_sign = c;
      lx_mode = LX_SIGN;
    end else begin
      lit_begin(c);
    end
  endfunction

  function automatic void lit_step(logic [7:0] c);
    if (is_space(c) || struct_kind(c) != jbt_pkg::TK_CONTENT) begin
      push_token(lit_kind(), 8'h00);
      lx_mode = LX_IDLE;
      idle_byte(c);
    end else begin
      lit_add(c);
    end
  endfunction

  function automatic void number_end(logic [7:0] c);
    push_token(lx_float ? jbt_pkg::TK_FLOAT_END : jbt_pkg::TK_INT_END, 8'h00);
    lx_float = 1'b0;
    lx_mode = LX_IDLE;
    idle_byte(c);
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    case (lx_mode)
      LX_COMMENT: if (c == jbt_pkg::CH_NL) lx_mode = LX_IDLE;
      LX_STRING: begin
        if (c == jbt_pkg::CH_QUOTE) begin
          push_token(jbt_pkg::TK_STR_END, 8'h00);
          lx_mode = LX_IDLE;
        end else begin
          push_token(jbt_pkg::TK_CONTENT, c);
        end
      end
      LX_SIGN: begin
        if (is_digit(c)) begin
          lx_float = 1'b0;
          push_token(jbt_pkg::TK_CONTENT, held_sign);
          push_token(jbt_pkg::TK_CONTENT, c);
          lx_mode = LX_INT;
        end else begin
          lit_begin(held_sign);
          lit_step(c);
        end
        held_sign = 8'h00;
      end
      LX_INT: begin
        if (is_digit(c)) begin
          push_token(jbt_pkg::TK_CONTENT, c);
        end else if (c == jbt_pkg::CH_DOT) begin
          lx_float = 1'b1;
          push_token(jbt_pkg::TK_CONTENT, c);
          lx_mode = LX_FRAC;
        end else if (c == jbt_pkg::CH_E_LO || c == jbt_pkg::CH_E_UP) begin
          lx_float = 1'b1;
          push_token(jbt_pkg::TK_CONTENT, c);
          lx_mode = LX_EXP;
        end else begin
          number_end(c);
        end
      end
      LX_FRAC: begin
        if (is_digit(c)) begin
          push_token(jbt_pkg::TK_CONTENT, c);
        end else if (c == jbt_pkg::CH_E_LO || c == jbt_pkg::CH_E_UP) begin
          push_token(jbt_pkg::TK_CONTENT, c);
          lx_mode = LX_EXP;
        end else begin
          number_end(c);
        end
      end
      LX_EXP: begin
        if (is_digit(c) || c == jbt_pkg::CH_PLUS || c == jbt_pkg::CH_MINUS) begin
          push_token(jbt_pkg::TK_CONTENT, c);
          lx_mode = LX_EXPD;
        end else begin
          number_end(c);
        end
      end
      LX_EXPD: begin
        if (is_digit(c)) push_token(jbt_pkg::TK_CONTENT, c);
        else number_end(c);
      end
      LX_LIT: lit_step(c);
      default: begin
        lx_mode = LX_IDLE;
        idle_byte(c);
      end
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic eoi);
    int first;
    first = expected_tokens.size();
    if (eoi) begin
      case (lx_mode)
        LX_STRING: push_token(jbt_pkg::TK_STR_END, 8'h00);
        LX_SIGN:   push_token(jbt_pkg::TK_UNKNOWN, 8'h00);
        LX_INT, LX_FRAC, LX_EXP, LX_EXPD:
          push_token(lx_float ? jbt_pkg::TK_FLOAT_END : jbt_pkg::TK_INT_END, 8'h00);
        LX_LIT:    push_token(lit_kind(), 8'h00);
        default: ;
      endcase
      push_token(jbt_pkg::TK_EOF, 8'h00);
      lexer_clear();
    end else begin
      lex_byte(c);
    end
    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  // source side
  always @(posedge clk) begin
    if (rst) begin
      byte_in_ch.valid        <= 1'b0;
      byte_in_ch.in_byte      <= 8'h00;
      byte_in_ch.end_of_input <= 1'b0;
    end else begin
      if (byte_in_ch.valid && byte_in_ch.ready) begin
        predict_tokens(byte_in_ch.in_byte, byte_in_ch.end_of_input);
        pending_bytes.delete(0);
      end
      if (!byte_in_ch.valid || byte_in_ch.ready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          byte_in_ch.valid        <= 1'b1;
          byte_in_ch.in_byte      <= pending_bytes[0].ch;
          byte_in_ch.end_of_input <= pending_bytes[0].eoi;
        end else begin
          byte_in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // sink side and checking
  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      token_out_ch.ready <= 1'b0;
    end else begin
      token_out_ch.ready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);
      if (token_out_ch.valid && token_out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token transfer: token_kind %0d content %0h last %0b",
                 token_out_ch.token_kind, token_out_ch.content, token_out_ch.last);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (token_out_ch.token_kind !== want.kind) begin
            $error("token_kind mismatch: expected %0d, actual %0d", want.kind,
                   token_out_ch.token_kind);
            fail_count++;
          end
          if (token_out_ch.content !== want.text) begin
            $error("content mismatch: expected %0h, actual %0h", want.text,
                   token_out_ch.content);
            fail_count++;
          end
          if (token_out_ch.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last,
                   token_out_ch.last);
            fail_count++;
          end
        end
      end
    end
  end

  // long sink hold-off while the source keeps offering
  initial begin
    while (!hold_go) @(negedge clk);
    @(posedge clk);
    hold_sink <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_sink <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus
  function automatic void queue_byte(logic [7:0] ch);
    lex_byte_t b;
    b.ch  = ch;
    b.eoi = 1'b0;
    pending_bytes = {pending_bytes, b};
    stim_count++;
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void queue_eoi();
    lex_byte_t b;
    b.ch  = 8'($urandom_range(255));
    b.eoi = 1'b1;
    pending_bytes = {pending_bytes, b};
    stim_count++;
  endfunction

  function automatic logic [7:0] rand_struct();
    logic [7:0] chars [6];
    chars = '{jbt_pkg::CH_LBRACE, jbt_pkg::CH_RBRACE, jbt_pkg::CH_LBRACKET,
              jbt_pkg::CH_RBRACKET, jbt_pkg::CH_COLON, jbt_pkg::CH_COMMA};
    return chars[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] rand_space();
    logic [7:0] chars [6];
    chars = '{jbt_pkg::CH_SPACE, jbt_pkg::CH_TAB, jbt_pkg::CH_NL, jbt_pkg::CH_VT,
              jbt_pkg::CH_FF, jbt_pkg::CH_CR};
    return chars[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] rand_digit();
    return jbt_pkg::CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic void add_break();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) queue_byte(rand_space());
    else if (sel < 85) queue_byte(rand_struct());
  endfunction

  function automatic void add_number();
    int n;
    if ($urandom_range(9) < 3) begin
      queue_byte($urandom_range(1) ? jbt_pkg::CH_MINUS : jbt_pkg::CH_PLUS);
      if ($urandom_range(7) == 0) begin
        queue_byte(8'($urandom_range(255)));
        return;
      end
    end
    n = $urandom_range(4, 1);
    repeat (n) queue_byte(rand_digit());
    if ($urandom_range(99) < 35) begin
      queue_byte(jbt_pkg::CH_DOT);
      n = $urandom_range(3);
      repeat (n) queue_byte(rand_digit());
    end
    if ($urandom_range(99) < 30) begin
      queue_byte($urandom_range(1) ? jbt_pkg::CH_E_LO : jbt_pkg::CH_E_UP);
      if ($urandom_range(1))
        queue_byte($urandom_range(1) ? jbt_pkg::CH_MINUS : jbt_pkg::CH_PLUS);
      n = $urandom_range(3);
      repeat (n) queue_byte(rand_digit());
    end
    add_break();
  endfunction

  function automatic void add_literal();
    string words [8];
    string w;
    int    n;
    words = '{"true", "false", "null", "nul", "falsey", "nullnull", "t\"/u", "x/y"};
    if ($urandom_range(99) < 60) begin
      w = words[$urandom_range(2)];
      if ($urandom_range(3) == 0) w = words[$urandom_range(7)];
      if ($urandom_range(5) == 0) w[$urandom_range(w.len() - 1)] = 8'($urandom_range(122, 97));
      queue_text(w);
    end else begin
      n = $urandom_range(8, 1);
      repeat (n) queue_byte($urandom_range(1) ? 8'($urandom_range(122, 97))
                                              : 8'($urandom_range(255)));
    end
    add_break();
  endfunction

  function automatic void add_fragment();
    int sel;
    int n;
    logic [7:0] c;
    sel = $urandom_range(99);
    if (sel < 15) begin
      queue_byte(rand_struct());
    end else if (sel < 25) begin
      queue_byte(rand_space());
    end else if (sel < 42) begin
      queue_byte(jbt_pkg::CH_QUOTE);
      n = $urandom_range(6);
      repeat (n) queue_byte(8'($urandom_range(255)));
      if ($urandom_range(19) != 0) queue_byte(jbt_pkg::CH_QUOTE);
    end else if (sel < 62) begin
      add_number();
    end else if (sel < 80) begin
      add_literal();
    end else if (sel < 86) begin
      queue_byte(jbt_pkg::CH_SLASH);
      n = $urandom_range(5);
      repeat (n) begin
        c = 8'($urandom_range(255));
        queue_byte((c == jbt_pkg::CH_NL) ? jbt_pkg::CH_SPACE : c);
      end
      queue_byte(jbt_pkg::CH_NL);
    end else if (sel < 97) begin
      queue_byte(8'($urandom_range(255)));
    end else begin
      queue_eoi();
    end
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_in_ch.valid || expected_tokens.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(int src_pct, int sink_pct);
    @(negedge clk);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    stim_count     = 0;
    while (stim_count < PHASE_ITEMS) add_fragment();
    wait_drained();
  endtask

  initial begin
    lexer_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    queue_text("{\"a\":[-7,1.5E+]}");
    queue_text("true");
    queue_byte(jbt_pkg::CH_NL);
    queue_text("false");
    queue_byte(jbt_pkg::CH_FF);
    queue_text("null");
    queue_byte(jbt_pkg::CH_VT);
    queue_text("+");
    queue_byte(jbt_pkg::CH_TAB);
    queue_text("1e");
    queue_eoi();
    queue_byte(jbt_pkg::CH_QUOTE);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_eoi();
    queue_text("/q");
    queue_eoi();
    wait_drained();

    @(negedge clk);
    hold_go = 1'b1;
    run_random(0, 0);
    run_random(52, 0);
    run_random(0, 52);
    run_random(8, 8);

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
